>>> hdl/krlp_pkg.sv
package krlp_pkg;

   localparam int RULE_COUNT = 8;
   localparam int HOLD_BITS  = 16;
   localparam int RULE_SLOTS = 8;
   localparam int INDEX_BITS = 3;
   localparam int WORD_BITS  = 33;
   localparam int THR_BITS   = 16;
   localparam int CMP_BITS   = 32;

   localparam logic [4:0] EVENT_KEY   = 5'd1;
   localparam logic [1:0] KEY_RELEASE = 2'd0;
   localparam logic [1:0] KEY_PRESS   = 2'd1;
   localparam logic       REQ_EVENT   = 1'b0;
   localparam logic       REQ_TICK    = 1'b1;

   typedef enum logic [1:0] {
      TRIG_PRESS   = 2'd0,
      TRIG_RELEASE = 2'd1,
      TRIG_LONG    = 2'd2,
      TRIG_NONE    = 2'd3
   } trig_type;

   typedef struct packed {
      logic       req_type;
      logic [3:0] device_id;
      logic [4:0] event_type;
      logic [9:0] key_code;
      logic [1:0] key_value;
   } key_req_type;

endpackage

>>> hdl/krlp_rule_slot.sv
module krlp_rule_slot (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cfg_we,
   input  logic [krlp_pkg::WORD_BITS-1:0]       cfg_word,
   input  logic                                 step,
   input  krlp_pkg::key_req_type                req,
   output logic                                 fire
);

   logic [krlp_pkg::WORD_BITS-1:0] word_ff;
   logic                           active_ff, active_in;
   logic                           fired_ff, fired_in;
   logic [krlp_pkg::HOLD_BITS-1:0] ms_ff, ms_in, ms_inc;
   logic                           rule_valid;
   logic                           hit;
   logic                           reached;
   logic                           reached_inc;
   krlp_pkg::trig_type             trig;
   logic [krlp_pkg::THR_BITS-1:0]  thr;

   assign rule_valid = word_ff[32];
   assign trig       = krlp_pkg::trig_type'(word_ff[17:16]);
   assign thr        = word_ff[15:0];
   assign hit        = rule_valid && req.event_type == krlp_pkg::EVENT_KEY
                       && word_ff[31:28] == req.device_id && word_ff[27:18] == req.key_code;
   assign ms_inc      = (ms_ff == '1) ? ms_ff : ms_ff + 1'b1;
   assign reached     = krlp_pkg::CMP_BITS'(ms_ff) >= krlp_pkg::CMP_BITS'(thr);
   assign reached_inc = krlp_pkg::CMP_BITS'(ms_inc) >= krlp_pkg::CMP_BITS'(thr);

   always_comb begin
      fire      = 1'b0;
      active_in = active_ff;
      fired_in  = fired_ff;
      ms_in     = ms_ff;
      if (req.req_type == krlp_pkg::REQ_TICK) begin
         if (rule_valid && trig == krlp_pkg::TRIG_LONG && active_ff && !fired_ff) begin
            ms_in = ms_inc;
            if (reached_inc) begin
               fire     = 1'b1;
               fired_in = 1'b1;
            end
         end
      end else if (hit) begin
         if (req.key_value == krlp_pkg::KEY_PRESS) begin
            if (trig == krlp_pkg::TRIG_PRESS) begin
               fire = 1'b1;
            end else if (trig == krlp_pkg::TRIG_LONG) begin
               active_in = 1'b1;
               fired_in  = 1'b0;
               ms_in     = '0;
            end
         end else if (req.key_value == krlp_pkg::KEY_RELEASE) begin
            if (trig == krlp_pkg::TRIG_RELEASE) begin
               fire = 1'b1;
            end else if (trig == krlp_pkg::TRIG_LONG && active_ff) begin
               fire      = !fired_ff && reached;
               active_in = 1'b0;
               fired_in  = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff   <= '0;
         active_ff <= 1'b0;
         fired_ff  <= 1'b0;
         ms_ff     <= '0;
      end else if (cfg_we) begin
         word_ff   <= cfg_word;
         active_ff <= 1'b0;
         fired_ff  <= 1'b0;
         ms_ff     <= '0;
      end else if (step) begin
         active_ff <= active_in;
         fired_ff  <= fired_in;
         ms_ff     <= ms_in;
      end
   end

endmodule

>>> hdl/key_rule_press_long_press_detector.sv
// An accepted request is registered in req_ff and evaluated once all results of the previous
// request have been taken; the rule slots then load its results into pend_ff for output.
// Throughput: one request per cycle while each request fires at most one rule and rsp_stall is
// low; a request firing several rules holds the output, giving one result per unstalled cycle.
// Reset is synchronous and active high; it clears all rule words and per-rule hold state.
module key_rule_press_long_press_detector (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_type,
   input  logic [3:0]                           req_device_id,
   input  logic [4:0]                           req_event_type,
   input  logic [9:0]                           req_key_code,
   input  logic [1:0]                           req_key_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [krlp_pkg::INDEX_BITS-1:0]      rsp_rule_index,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [krlp_pkg::INDEX_BITS-1:0]      csr_index,
   input  logic [krlp_pkg::WORD_BITS-1:0]       csr_data
);

   krlp_pkg::key_req_type           req_ff;
   logic                            full_ff, full_in;
   logic [krlp_pkg::RULE_SLOTS-1:0] pend_ff, pend_in, pend_after, low_bit, fire;
   logic                            req_accept;
   logic                            rsp_take;
   logic                            advance;

   assign csr_ready  = 1'b1;
   assign rsp_valid  = |pend_ff;
   assign rsp_take   = rsp_valid && !rsp_stall;
   assign low_bit    = pend_ff & (~pend_ff + 1'b1);
   assign pend_after = rsp_take ? (pend_ff & ~low_bit) : pend_ff;
   assign advance    = full_ff && (pend_after == '0);
   assign req_stall  = full_ff && !advance;
   assign req_accept = req_valid && !req_stall;
   assign full_in    = req_accept || (full_ff && !advance);
   assign pend_in    = advance ? fire : pend_after;
   assign rsp_last   = (pend_ff & (pend_ff - 1'b1)) == '0;

   always_comb begin
      rsp_rule_index = '0;
      for (int i = krlp_pkg::RULE_SLOTS - 1; i >= 0; i--) begin
         if (pend_ff[i]) begin
            rsp_rule_index = krlp_pkg::INDEX_BITS'(i);
         end
      end
   end

   genvar g;
   generate
      for (g = 0; g < krlp_pkg::RULE_SLOTS; g++) begin : g_rule
         if (g < krlp_pkg::RULE_COUNT) begin : g_used
            krlp_rule_slot u_slot (
               .clock    (clock),
               .reset    (reset),
               .cfg_we   (csr_valid && csr_index == krlp_pkg::INDEX_BITS'(g)),
               .cfg_word (csr_data),
               .step     (advance),
               .req      (req_ff),
               .fire     (fire[g])
            );
         end else begin : g_unused
            assign fire[g] = 1'b0;
         end
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         pend_ff <= '0;
      end else begin
         full_ff <= full_in;
         pend_ff <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         req_ff.req_type   <= req_type;
         req_ff.device_id  <= req_device_id;
         req_ff.event_type <= req_event_type;
         req_ff.key_code   <= req_key_code;
         req_ff.key_value  <= req_key_value;
      end
   end

endmodule

>>> hdl/krlp_checker.sv
module krlp_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [krlp_pkg::INDEX_BITS-1:0] rsp_rule_index,
   input logic                            rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_rule_index) && $stable(rsp_last))
      else $error("Stalled result changed.");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("Result burst ended without a last marker.");

   a_burst_ascending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_rule_index > $past(rsp_rule_index))
      else $error("Rule indices within one request are not ascending.");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("Request stalled while no result is pending.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_rule_index != '1)
      else $error("Highest rule index shown without the last marker.");

endmodule

bind key_rule_press_long_press_detector krlp_checker u_krlp_checker (.*);
